/* sv/bdar_pkg.sv */
// Package for the button debounce and autorepeat unit: widths, codes and reset values.
`default_nettype none

package bdar_pkg;

   // Field and register widths
   localparam int unsigned CountWidth = 16;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned ReqDataWidth = 8;
   localparam int unsigned RspDataWidth = 8;

   // Register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] CSR_ACTIVE_LEVEL = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DEBOUNCE_TICKS = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_REPEAT_START = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_REPEAT_INTERVAL = 2'd3;

   // Register reset values
   localparam logic CSR_ACTIVE_LEVEL_RST = 1'b0;
   localparam logic [CountWidth-1:0] CSR_DEBOUNCE_TICKS_RST = 16'd5;
   localparam logic [CountWidth-1:0] CSR_REPEAT_START_RST = 16'd500;
   localparam logic [CountWidth-1:0] CSR_REPEAT_INTERVAL_RST = 16'd0;

   // Hold counter limits: the all-ones value is pulled back to the hold maximum
   localparam logic [CountWidth-1:0] COUNT_WRAP_MARK = 16'hFFFF;
   localparam logic [CountWidth-1:0] COUNT_HOLD_MAX = 16'hFFFE;

   // Long press mark codes
   localparam logic [1:0] LONG_NONE = 2'd0;
   localparam logic [1:0] LONG_NEW = 2'd1;
   localparam logic [1:0] LONG_HELD = 2'd2;

   // One result item
   typedef struct packed {
      logic released;
      logic pushed_long;
      logic pushed;
      logic changed;
      logic pressed;
   } result_type;

endpackage : bdar_pkg

`default_nettype wire

/* sv/button_debounce_autorepeat_unit.sv */
// Top level of the button debounce and autorepeat unit.
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  req_tdata[0] pin_level
//  rsp      out        rsp_tvalid/rsp_tready  rsp_tdata[4:0] pressed..released
//  csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// Each transaction passes an input register and a result register; one
// transaction per cycle is sustained while rsp is not stalled. The hold counter
// update is a single add/compare/subtract path between the two registers.
// Synchronous active-high reset clears the state and loads register defaults.
// A stalled rsp side holds its result; req stays ready while a result waits
// only if the input register is empty or the result is leaving.
`default_nettype none

module button_debounce_autorepeat_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // req_tdata: [0] pin_level, [7:1] zero
   input  wire logic                                   req_tvalid,
   output      logic                                   req_tready,
   input  wire logic [bdar_pkg::ReqDataWidth-1:0]      req_tdata,
   // rsp_tdata: [0] pressed, [1] changed, [2] pushed, [3] pushed_long,
   //            [4] released, [7:5] zero
   output      logic                                   rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output      logic [bdar_pkg::RspDataWidth-1:0]      rsp_tdata,
   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [bdar_pkg::CsrIndexWidth-1:0]     csr_index,
   input  wire logic [bdar_pkg::CsrDataWidth-1:0]      csr_data
);

   localparam int unsigned CW = bdar_pkg::CountWidth;

   // Configuration registers
   logic          active_level_ff;
   logic [CW-1:0] debounce_ticks_ff;
   logic [CW-1:0] repeat_start_ff;
   logic [CW-1:0] repeat_interval_ff;

   // Tick state
   logic [CW-1:0] hold_count_ff, hold_count_in;
   logic          pressed_ff, pressed_in;
   logic [1:0]    long_mark_ff, long_mark_in;

   // Pipeline registers
   logic                  in_valid_ff;
   logic                  in_level_ff;
   logic                  rsp_valid_ff;
   bdar_pkg::result_type  rsp_data_ff, rsp_data_in;

   logic advance;
   logic [CW-1:0] count_inc, count_step, count_sat;
   logic rise, fall, repeat_hit;

   // Handshakes
   assign advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff <= bdar_pkg::CSR_ACTIVE_LEVEL_RST;
         debounce_ticks_ff <= bdar_pkg::CSR_DEBOUNCE_TICKS_RST;
         repeat_start_ff <= bdar_pkg::CSR_REPEAT_START_RST;
         repeat_interval_ff <= bdar_pkg::CSR_REPEAT_INTERVAL_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            bdar_pkg::CSR_ACTIVE_LEVEL: active_level_ff <= csr_data[0];
            bdar_pkg::CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_data;
            bdar_pkg::CSR_REPEAT_START: repeat_start_ff <= csr_data;
            bdar_pkg::CSR_REPEAT_INTERVAL: repeat_interval_ff <= csr_data;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_level_ff <= req_tdata[0];
      end
   end

   // Tick update: count, pressed state, long mark, events
   assign count_inc = hold_count_ff + CW'(1);

   always_comb begin
      pressed_in = pressed_ff;
      long_mark_in = long_mark_ff;
      if (in_level_ff == active_level_ff) begin
         count_step = count_inc;
         if (count_inc >= debounce_ticks_ff) begin
            pressed_in = 1'b1;
         end
         if (count_inc == repeat_start_ff) begin
            long_mark_in = bdar_pkg::LONG_NEW;
         end else if (long_mark_ff != bdar_pkg::LONG_NONE) begin
            long_mark_in = bdar_pkg::LONG_HELD;
         end
      end else begin
         count_step = '0;
         pressed_in = 1'b0;
      end

      // saturate below all-ones
      count_sat = (count_step == bdar_pkg::COUNT_WRAP_MARK) ? bdar_pkg::COUNT_HOLD_MAX
                                                            : count_step;

      rise = !pressed_ff && pressed_in;
      fall = pressed_ff && !pressed_in;
      repeat_hit = !rise && (repeat_interval_ff != '0) && (count_sat >= repeat_start_ff);

      // autorepeat pulls the counter back, floored at zero
      if (repeat_hit) begin
         hold_count_in = (count_sat > repeat_interval_ff) ? count_sat - repeat_interval_ff
                                                          : '0;
      end else begin
         hold_count_in = count_sat;
      end

      rsp_data_in.pressed = pressed_in;
      rsp_data_in.changed = rise || fall;
      rsp_data_in.pushed = rise || repeat_hit;
      rsp_data_in.pushed_long = (long_mark_in == bdar_pkg::LONG_NEW);
      rsp_data_in.released = fall && (long_mark_in == bdar_pkg::LONG_NONE);

      // a press edge clears the mark after it has been reported
      if (rise) begin
         long_mark_in = bdar_pkg::LONG_NONE;
      end
   end

   // State and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_count_ff <= '0;
         pressed_ff <= 1'b0;
         long_mark_ff <= bdar_pkg::LONG_NONE;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            hold_count_ff <= hold_count_in;
            pressed_ff <= pressed_in;
            long_mark_ff <= long_mark_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b000, rsp_data_ff};

endmodule : button_debounce_autorepeat_unit

`default_nettype wire
